// ===== rtl/sua_pkg.sv =====
// ----------------------------------------------------------------------------
// sua_pkg
// Types, codes and helper functions shared by the uplink ack/retry sender.
// ----------------------------------------------------------------------------
package sua_pkg;

	localparam int unsigned PAYLOAD_BITS_DEF = 64;

	localparam logic [15:0] LINK_REQ    = 16'd20;
	localparam logic [7:0]  ACK_TYPE    = 8'd34;
	localparam logic [7:0]  ACK_MIN_LEN = 8'd9;

	localparam logic [11:0] RAC0_LO = 12'd630;
	localparam logic [11:0] RAC0_HI = 12'd808;
	localparam logic [11:0] RAC1_LO = 12'd1350;
	localparam logic [11:0] RAC1_HI = 12'd1528;
	localparam logic [11:0] RAC2_LO = 12'd2070;
	localparam logic [11:0] RAC2_HI = 12'd2248;

	localparam logic [2:0] REG_OWN_ID   = 3'd0;
	localparam logic [2:0] REG_PRIO     = 3'd1;
	localparam logic [2:0] REG_NET      = 3'd2;
	localparam logic [2:0] REG_RAC_LIM  = 3'd3;
	localparam logic [2:0] REG_MAX_RTY  = 3'd4;
	localparam logic [2:0] REG_ACK_TO   = 3'd5;
	localparam logic [2:0] REG_HOLD     = 3'd6;

	typedef enum logic [2:0] {
		F_SEND = 3'd0,
		F_SLOT = 3'd1,
		F_PKT  = 3'd2,
		F_MAC  = 3'd3,
		F_MS   = 3'd4
	} func_t;

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_WAIT = 4'b0010,
		M_SEND = 4'b0100,
		M_ABN  = 4'b1000
	} mode_t;

	typedef enum logic [3:0] {
		S_NONE      = 4'd0,
		S_ACCEPTED  = 4'd1,
		S_BUSY      = 4'd2,
		S_BAD_LINK  = 4'd3,
		S_NOT_RAC   = 4'd4,
		S_MISSED    = 4'd5,
		S_MAC_DENY  = 4'd6,
		S_TRANSMIT  = 4'd7,
		S_ACKED     = 4'd8,
		S_NACK_FAIL = 4'd9,
		S_TMO_FAIL  = 4'd10,
		S_RECOVERED = 4'd11
	} status_t;

	typedef struct packed {
		logic [31:0] own_id;
		logic [7:0]  prio;
		logic [7:0]  net;
		logic [7:0]  rac_limit;
		logic [3:0]  max_retries;
		logic [15:0] ack_ms;
		logic [15:0] hold_ms;
	} sua_cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic        held_vld;
		logic [11:0] held_slot;
		logic [7:0]  held_link;
		logic        pending;
		logic [3:0]  tries;
		logic        mac_ok;
		logic [15:0] ack_timer;
		logic        ack_running;
		logic [15:0] hold_timer;
		logic        hold_running;
	} sua_state_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [11:0] cur_slot;
		logic [11:0] tgt_slot;
		logic [15:0] link_id;
		logic [7:0]  pkt_len;
		logic [7:0]  pkt_type;
		logic [31:0] pkt_ship_id;
		logic [7:0]  pkt_nack;
		logic [7:0]  rac_count;
	} sua_ev_t;

	typedef struct packed {
		status_t status;
		logic    load;
		logic    tx;
	} sua_res_t;

	localparam sua_cfg_t CFG_RESET = '{
		own_id: 32'd0, prio: 8'd0, net: 8'd0, rac_limit: 8'd3,
		max_retries: 4'd3, ack_ms: 16'd5000, hold_ms: 16'd2000
	};

	localparam sua_state_t ST_RESET = '{
		mode: M_IDLE, held_vld: 1'b0, held_slot: 12'd0, held_link: 8'd0,
		pending: 1'b0, tries: 4'd0, mac_ok: 1'b0, ack_timer: 16'd0,
		ack_running: 1'b0, hold_timer: 16'd0, hold_running: 1'b0
	};

	function automatic logic in_rac(logic [11:0] s);
		return (s >= RAC0_LO && s <= RAC0_HI) || (s >= RAC1_LO && s <= RAC1_HI) ||
		       (s >= RAC2_LO && s <= RAC2_HI);
	endfunction

	function automatic sua_state_t sua_clear(sua_state_t s);
		sua_state_t r;
		r          = s;
		r.pending  = 1'b0;
		r.held_vld = 1'b0;
		r.tries    = 4'd0;
		return r;
	endfunction

	function automatic sua_state_t sua_enter(sua_state_t s, mode_t nx, logic [15:0] hold_ms);
		sua_state_t r;
		r = s;
		if (s.mode != nx) begin
			r.mode = nx;
			if (nx == M_ABN) begin
				r.hold_timer   = hold_ms;
				r.hold_running = 1'b1;
			end else if (nx == M_IDLE) begin
				r.ack_timer    = 16'd0;
				r.ack_running  = 1'b0;
				r.hold_timer   = 16'd0;
				r.hold_running = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic logic [1:0] mode_code(mode_t m);
		logic [1:0] c;
		unique case (m)
			M_IDLE:  c = 2'd0;
			M_WAIT:  c = 2'd1;
			M_SEND:  c = 2'd2;
			M_ABN:   c = 2'd3;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/sua_step.sv =====
// ----------------------------------------------------------------------------
// sua_step
// Next-state and status logic for one request through the sender state machine.
// ----------------------------------------------------------------------------
module sua_step (
	input  sua_pkg::sua_state_t st,
	input  sua_pkg::sua_cfg_t   cfg,
	input  sua_pkg::sua_ev_t    ev,
	output sua_pkg::sua_state_t st_next,
	output sua_pkg::sua_res_t   res
);
	import sua_pkg::*;

	always_comb begin
		sua_state_t n;
		status_t    sts;
		logic       tx;
		logic       load;
		logic       ack_fire;
		logic       hold_fire;
		logic       fail;
		status_t    fail_code;

		n         = st;
		sts       = S_NONE;
		tx        = 1'b0;
		load      = 1'b0;
		ack_fire  = 1'b0;
		hold_fire = 1'b0;
		fail      = 1'b0;
		fail_code = S_NONE;

		unique case (ev.func)
			F_SEND: begin
				if (st.mode != M_IDLE) sts = S_BUSY;
				else if (ev.link_id != LINK_REQ) sts = S_BAD_LINK;
				else if (!in_rac(ev.tgt_slot)) sts = S_NOT_RAC;
				else if (ev.cur_slot > ev.tgt_slot) sts = S_MISSED;
				else begin
					n.held_vld  = 1'b1;
					n.held_slot = ev.tgt_slot;
					n.held_link = ev.link_id[7:0];
					n.pending   = 1'b1;
					n.tries     = 4'd0;
					n           = sua_enter(n, M_WAIT, cfg.hold_ms);
					load        = 1'b1;
					sts         = S_ACCEPTED;
				end
			end
			F_SLOT: begin
				if (st.mode == M_WAIT && st.held_vld && st.held_slot >= 12'd2 &&
				    ev.cur_slot == st.held_slot - 12'd2) begin
					if (st.mac_ok) begin
						tx            = st.pending;
						n             = sua_enter(n, M_SEND, cfg.hold_ms);
						n.ack_timer   = cfg.ack_ms;
						n.ack_running = 1'b1;
						sts           = S_TRANSMIT;
					end else begin
						sts = S_MAC_DENY;
					end
				end
			end
			F_PKT: begin
				if (ev.pkt_len != 8'd0 && ev.pkt_type == ACK_TYPE && st.mode == M_SEND &&
				    ev.pkt_len >= ACK_MIN_LEN && ev.pkt_ship_id == cfg.own_id) begin
					if (ev.pkt_nack == 8'd0) begin
						n.ack_running = 1'b0;
						n.ack_timer   = 16'd0;
						n             = sua_enter(sua_clear(n), M_IDLE, cfg.hold_ms);
						sts           = S_ACKED;
					end else begin
						fail      = 1'b1;
						fail_code = S_NACK_FAIL;
					end
				end
			end
			F_MAC: begin
				n.mac_ok = (cfg.prio == 8'd0) && (cfg.net == 8'd0) &&
				           (ev.rac_count < cfg.rac_limit);
			end
			F_MS: begin
				if (st.ack_running) begin
					if (st.ack_timer <= 16'd1) begin
						n.ack_running = 1'b0;
						n.ack_timer   = 16'd0;
						ack_fire      = 1'b1;
					end else begin
						n.ack_timer = st.ack_timer - 16'd1;
					end
				end
				if (st.hold_running) begin
					if (st.hold_timer <= 16'd1) begin
						n.hold_running = 1'b0;
						n.hold_timer   = 16'd0;
						hold_fire      = 1'b1;
					end else begin
						n.hold_timer = st.hold_timer - 16'd1;
					end
				end
				if (ack_fire && st.mode == M_SEND) begin
					fail      = 1'b1;
					fail_code = S_TMO_FAIL;
				end else if (hold_fire && st.mode == M_ABN) begin
					n   = sua_enter(sua_clear(n), M_IDLE, cfg.hold_ms);
					sts = S_RECOVERED;
				end
			end
			default: ;
		endcase

		if (fail) begin
			n.tries = st.tries + 4'd1;
			if (n.tries < cfg.max_retries) begin
				n = sua_enter(n, M_WAIT, cfg.hold_ms);
			end else begin
				n   = sua_enter(sua_clear(n), M_ABN, cfg.hold_ms);
				sts = fail_code;
			end
		end

		st_next    = n;
		res.status = sts;
		res.load   = load;
		res.tx     = tx;
	end

endmodule

// ===== rtl/slotted_uplink_ack_retry_fsm_top.sv =====
// ----------------------------------------------------------------------------
// slotted_uplink_ack_retry_fsm_top
// Stop-and-wait sender for a slotted short message with acknowledgement.
// ----------------------------------------------------------------------------
// Each request (send, slot tick, packet, MAC update or ms tick) gives exactly
// one result. A request is registered on entry, passes one stage of compare and
// counter logic against the state registers, and lands in the result register;
// one request per cycle is sustained as long as out_stall stays low. While a
// result waits, the input register takes at most one more request, and then
// in_stall rises and stays high for as long as out_stall does.
// Configuration writes take effect on the edge they are presented and are meant
// for times when no request is in flight.
module slotted_uplink_ack_retry_fsm_top #(
	parameter int unsigned PAYLOAD_BITS = sua_pkg::PAYLOAD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [11:0] current_slot,
	input  logic [11:0] target_slot,
	input  logic [15:0] link_id,
	input  logic [31:0] dest_id,
	input  logic [63:0] payload,
	input  logic [7:0]  pkt_len,
	input  logic [7:0]  pkt_type,
	input  logic [31:0] pkt_ship_id,
	input  logic [7:0]  pkt_nack,
	input  logic [7:0]  rac_count,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [1:0]  fsm_state,
	output logic [11:0] tx_slot,
	output logic [7:0]  tx_link_id,
	output logic [31:0] tx_src_id,
	output logic [31:0] tx_dest_id,
	output logic [63:0] tx_payload,
	output logic [3:0]  retry_count
);
	import sua_pkg::*;

	sua_cfg_t   cfg_q;
	sua_state_t st_q;
	sua_state_t st_next;
	sua_res_t   res;

	logic                    valid_s1;
	sua_ev_t                 ev_s1;
	logic [31:0]             dest_s1;
	logic [63:0]             payload_s1;

	logic [31:0]             held_dest_q;
	logic [PAYLOAD_BITS-1:0] held_data_q;

	logic                    valid_s2;
	status_t                 status_s2;
	logic [1:0]              state_s2;
	logic [11:0]             tx_slot_s2;
	logic [7:0]              tx_link_s2;
	logic [31:0]             tx_src_s2;
	logic [31:0]             tx_dest_s2;
	logic [63:0]             tx_data_s2;
	logic [3:0]              tries_s2;

	logic s2_ready;
	logic adv;

	assign s2_ready = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && s2_ready;
	assign in_stall = valid_s1 && !s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_OWN_ID:  cfg_q.own_id      <= cfg_data;
				REG_PRIO:    cfg_q.prio        <= cfg_data[7:0];
				REG_NET:     cfg_q.net         <= cfg_data[7:0];
				REG_RAC_LIM: cfg_q.rac_limit   <= cfg_data[7:0];
				REG_MAX_RTY: cfg_q.max_retries <= cfg_data[3:0];
				REG_ACK_TO:  cfg_q.ack_ms      <= cfg_data[15:0];
				REG_HOLD:    cfg_q.hold_ms     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	sua_step u_step (
		.st      (st_q),
		.cfg     (cfg_q),
		.ev      (ev_s1),
		.st_next (st_next),
		.res     (res)
	);

	// drop the exchange when the station identity changes mid-flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (cfg_wr_en && cfg_index == REG_OWN_ID && st_q.mode != M_IDLE) begin
			st_q <= sua_enter(sua_clear(st_q), M_IDLE, cfg_q.hold_ms);
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ev_s1.func        <= func;
			ev_s1.cur_slot    <= current_slot;
			ev_s1.tgt_slot    <= target_slot;
			ev_s1.link_id     <= link_id;
			ev_s1.pkt_len     <= pkt_len;
			ev_s1.pkt_type    <= pkt_type;
			ev_s1.pkt_ship_id <= pkt_ship_id;
			ev_s1.pkt_nack    <= pkt_nack;
			ev_s1.rac_count   <= rac_count;
			dest_s1           <= dest_id;
			payload_s1        <= payload;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.load) begin
			held_dest_q <= dest_s1;
			held_data_q <= payload_s1[PAYLOAD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2  <= res.status;
			state_s2   <= mode_code(st_next.mode);
			tries_s2   <= st_next.tries;
			tx_slot_s2 <= res.tx ? st_q.held_slot : 12'd0;
			tx_link_s2 <= res.tx ? st_q.held_link : 8'd0;
			tx_src_s2  <= res.tx ? cfg_q.own_id : 32'd0;
			tx_dest_s2 <= res.tx ? held_dest_q : 32'd0;
			tx_data_s2 <= res.tx ? 64'(held_data_q) : 64'd0;
		end
	end

	assign out_valid   = valid_s2;
	assign status      = status_s2;
	assign fsm_state   = state_s2;
	assign tx_slot     = tx_slot_s2;
	assign tx_link_id  = tx_link_s2;
	assign tx_src_id   = tx_src_s2;
	assign tx_dest_id  = tx_dest_s2;
	assign tx_payload  = tx_data_s2;
	assign retry_count = tries_s2;

`ifndef SYNTHESIS
	a_pending_active: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pending |-> (st_q.mode == M_WAIT || st_q.mode == M_SEND))
		else $error("pending request outside wait/send");

	a_idle_timers_off: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode == M_IDLE |-> (!st_q.ack_running && !st_q.hold_running))
		else $error("timer running in idle");

	a_wait_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode == M_WAIT |-> st_q.held_vld)
		else $error("wait state without a held slot");

	a_abn_hold_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == M_ABN && $past(st_q.mode) != M_ABN) |-> st_q.hold_running)
		else $error("abnormal entered without hold timer");
`endif

endmodule
